FILE: src/lrba_pkg.sv
// ----------------------------------------------------------------------------
// lrba_pkg
// Shared types and constants for the leaky-ReLU backprop accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
package lrba_pkg;
    localparam int MaxNeurons   = 64;
    localparam int NumGroups    = 5;
    localparam int MaxGroupSize = 64;
    localparam int PropGroup    = 3;
    localparam int LeakQ24      = 167772;

    localparam int NW = $clog2(MaxNeurons);
    localparam int EW = $clog2(MaxGroupSize);
    localparam int GW = 3;
    localparam int WDEPTH = MaxNeurons * NumGroups * MaxGroupSize;
    localparam int WAW = $clog2(WDEPTH);
    localparam int AAW = $clog2(NumGroups * MaxGroupSize);
    localparam int CW = 7;

    localparam logic [2:0] REQ_LOAD_ACT = 3'd0;
    localparam logic [2:0] REQ_LOAD_WGT = 3'd1;
    localparam logic [2:0] REQ_BACKPROP = 3'd2;
    localparam logic [2:0] REQ_READ     = 3'd3;
    localparam logic [2:0] REQ_CLEAR    = 3'd4;

    localparam logic [1:0] SEL_WUPD = 2'd0;
    localparam logic [1:0] SEL_BIAS = 2'd1;
    localparam logic [1:0] SEL_PROP = 2'd2;

    localparam logic [2:0] CFG_NEURONS = 3'd0;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [5:0]         neuron;
        logic [2:0]         group;
        logic [5:0]         elem_index;
        logic signed [15:0] value;
        logic signed [15:0] neuron_act;
        logic [1:0]         read_sel;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic               bad_request;
    } rsp_t;

    // saturating add of a 33-bit signed delta into Q8.24
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [32:0] d);
        logic signed [33:0] s;
        s = 34'(a) + 34'(d);
        if (s > 34'sd2147483647) sat_add = 32'sh7fffffff;
        else if (s < -34'sd2147483648) sat_add = 32'sh80000000;
        else sat_add = s[31:0];
    endfunction
endpackage
`default_nettype wire

FILE: src/leaky_relu_backprop_accumulate.sv
// ----------------------------------------------------------------------------
// leaky_relu_backprop_accumulate
// Backward pass of one dense leaky-ReLU layer with five input groups.
// ----------------------------------------------------------------------------
// Usage: requests enter on req (req_valid/req_ready), one response per request
// leaves on rsp (rsp_valid/rsp_ready). Sizes are written through cfg_we,
// cfg_index, cfg_data while idle.
// A backprop walks every element in use of all five groups through one
// read-modify-write port of the weight-update memory; the propagated-error
// pass over group 3 runs in the same walk.
// Clear: a sweep over all 64*5*64 = 20480 entries of the weight-update memory,
// one entry per cycle; the same sweep runs after reset, during which no
// request is accepted (configuration writes still are).
// One request is worked at a time; req_ready is high again in the cycle after
// the response is loaded. The response sits in an output register; when the
// receiver stalls it holds there while the next request is taken and worked,
// and that result waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none
module leaky_relu_backprop_accumulate (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire lrba_pkg::req_t    req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output lrba_pkg::rsp_t         rsp,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [6:0]        cfg_data
);
    import lrba_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DEC, S_RD, S_RDW, S_BP, S_BPW, S_DONE
    } state_t;

    state_t state_reg;
    logic [CW-1:0] ncnt_reg;
    logic [CW-1:0] gsz_reg [NumGroups];
    req_t req_reg;
    rsp_t res_reg;
    rsp_t rsp_reg;
    logic rsp_valid_reg;
    logic [WAW:0] clr_reg;
    logic signed [15:0] err_reg;
    logic [GW-1:0] g_reg;
    logic [EW:0] e_reg;
    logic phase_reg;

    // memories
    logic signed [15:0] wmem [WDEPTH];
    logic signed [31:0] umem [WDEPTH];
    logic signed [15:0] amem [NumGroups * MaxGroupSize];
    logic signed [31:0] bmem [MaxNeurons];
    logic signed [31:0] pmem [MaxGroupSize];
    logic signed [15:0] wq, aq;
    logic signed [31:0] uq, bq, pq;

    // sizes in use
    logic [CW-1:0] nuse, guse, g3use, cur_use;
    logic n_ok, ge_ok, bad;
    always_comb
    begin
        nuse  = (ncnt_reg > CW'(MaxNeurons)) ? CW'(MaxNeurons) : ncnt_reg;
        guse  = (req_reg.group < GW'(NumGroups)) ? gsz_reg[req_reg.group] : gsz_reg[0];
        if (guse > CW'(MaxGroupSize)) guse = CW'(MaxGroupSize);
        g3use = (gsz_reg[PropGroup] > CW'(MaxGroupSize)) ? CW'(MaxGroupSize)
                                                         : gsz_reg[PropGroup];
        cur_use = (g_reg < GW'(NumGroups)) ? gsz_reg[g_reg] : '0;
        if (cur_use > CW'(MaxGroupSize)) cur_use = CW'(MaxGroupSize);
        n_ok  = CW'(req_reg.neuron) < nuse;
        ge_ok = req_reg.group < GW'(NumGroups) && CW'(req_reg.elem_index) < guse;
        case (req_reg.req_type)
            REQ_LOAD_ACT: bad = !ge_ok;
            REQ_LOAD_WGT: bad = !(n_ok && ge_ok);
            REQ_BACKPROP: bad = !n_ok;
            REQ_READ:
                case (req_reg.read_sel)
                    SEL_WUPD: bad = !(n_ok && ge_ok);
                    SEL_BIAS: bad = !n_ok;
                    SEL_PROP: bad = !(CW'(req_reg.elem_index) < g3use);
                    default:  bad = 1'b1;
                endcase
            REQ_CLEAR:    bad = 1'b0;
            default:      bad = 1'b1;
        endcase
    end

    // leak scaling, ties toward plus infinity via arithmetic shift
    logic signed [40:0] leak_prod;
    logic signed [15:0] err_eff;
    always_comb
    begin
        leak_prod = 41'(req_reg.value) * 41'sd167772 + 41'sd8388608;
        err_eff = (req_reg.neuron_act < 0) ? 16'(leak_prod >>> 24) : req_reg.value;
    end

    // addresses
    logic [WAW-1:0] waddr_req, waddr_bp, wp_addr;
    logic [AAW-1:0] aaddr_req, aaddr_bp;
    always_comb
    begin
        waddr_req = WAW'((32'(req_reg.neuron) * NumGroups + 32'(req_reg.group))
                         * MaxGroupSize + 32'(req_reg.elem_index));
        waddr_bp  = WAW'((32'(req_reg.neuron) * NumGroups + 32'(g_reg))
                         * MaxGroupSize + 32'(e_reg[EW-1:0]));
        wp_addr   = WAW'((32'(req_reg.neuron) * NumGroups + PropGroup)
                         * MaxGroupSize + 32'(e_reg[EW-1:0]));
        aaddr_req = AAW'(32'(req_reg.group) * MaxGroupSize + 32'(req_reg.elem_index));
        aaddr_bp  = AAW'(32'(g_reg) * MaxGroupSize + 32'(e_reg[EW-1:0]));
    end

    // products registered before accumulation
    logic signed [31:0] pu_reg, pp_reg;
    logic walk_p3;
    assign walk_p3 = (g_reg == GW'(PropGroup));

    // walk over, bias update on the way out
    logic walk_end;
    assign walk_end = (state_reg == S_BP) && (g_reg == GW'(NumGroups));

    // memory ports
    logic clr_busy;
    logic walking;
    assign clr_busy = (state_reg == S_CLR);
    assign walking  = (state_reg == S_BP || state_reg == S_BPW);
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DEC && req_reg.req_type == REQ_LOAD_WGT && !bad)
            wmem[waddr_req] <= req_reg.value;
        wq <= wmem[(state_reg == S_BP) ? wp_addr : waddr_req];
        if (state_reg == S_DEC && req_reg.req_type == REQ_LOAD_ACT && !bad)
            amem[aaddr_req] <= req_reg.value;
        aq <= amem[aaddr_bp];
        if (clr_busy)
            umem[clr_reg[WAW-1:0]] <= '0;
        else if (state_reg == S_BPW && phase_reg)
            umem[waddr_bp] <= sat_add(uq, 33'(pu_reg));
        uq <= umem[walking ? waddr_bp : waddr_req];
        if (clr_busy)
            bmem[clr_reg[NW-1:0]] <= '0;
        else if (walk_end)
            bmem[req_reg.neuron] <= sat_add(bq, 33'(err_reg) * 33'sd4096);
        bq <= bmem[req_reg.neuron];
        if (clr_busy)
            pmem[clr_reg[EW-1:0]] <= '0;
        else if (state_reg == S_BPW && phase_reg && walk_p3)
            pmem[e_reg[EW-1:0]] <= sat_add(pq, 33'(pp_reg));
        pq <= pmem[walking ? e_reg[EW-1:0] : req_reg.elem_index];
    end

    always_ff @(posedge clk)
    begin
        pu_reg <= 32'(err_reg) * 32'(aq);
        pp_reg <= 32'(err_reg) * 32'(wq);
    end

    // result moves to the output register once that register is free
    logic rsp_load;
    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            ncnt_reg      <= '0;
            for (int i = 0; i < NumGroups; i++) gsz_reg[i] <= '0;
            g_reg <= '0;
            e_reg <= '0;
            phase_reg <= 1'b0;
            req_reg <= '0;
            res_reg <= '0;
            rsp_reg <= '0;
            err_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_NEURONS) ncnt_reg <= cfg_data;
                else if (cfg_index <= 3'(NumGroups)) gsz_reg[cfg_index - 3'd1] <= cfg_data;
            end
            if (rsp_load) rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && rsp_ready) rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_CLR:
                begin
                    if (clr_reg == (WAW+1)'(WDEPTH - 1))
                    begin
                        clr_reg <= '0;
                        state_reg <= phase_reg ? S_DONE : S_IDLE;
                        phase_reg <= 1'b0;
                    end
                    else clr_reg <= clr_reg + 1'b1;
                end
                S_IDLE:
                    if (req_valid)
                    begin
                        req_reg <= req;
                        state_reg <= S_DEC;
                    end
                S_DEC:
                begin
                    err_reg <= err_eff;
                    res_reg <= '{read_data: '0, bad_request: bad};
                    g_reg <= '0;
                    e_reg <= '0;
                    phase_reg <= 1'b0;
                    if (bad) state_reg <= S_DONE;
                    else case (req_reg.req_type)
                        REQ_READ:     state_reg <= S_RD;
                        REQ_BACKPROP: state_reg <= S_BP;
                        REQ_CLEAR:
                        begin
                            state_reg <= S_CLR;
                            phase_reg <= 1'b1;
                        end
                        default:      state_reg <= S_DONE;
                    endcase
                end
                S_RD: state_reg <= S_RDW;
                S_RDW:
                begin
                    case (req_reg.read_sel)
                        SEL_WUPD: res_reg.read_data <= uq;
                        SEL_BIAS: res_reg.read_data <= bq;
                        default:  res_reg.read_data <= pq;
                    endcase
                    state_reg <= S_DONE;
                end
                // walk: S_BP issues reads, S_BPW waits product then writes
                S_BP:
                begin
                    if (g_reg == GW'(NumGroups)) state_reg <= S_DONE;
                    else if (CW'(e_reg) >= cur_use)
                    begin
                        g_reg <= g_reg + 1'b1;
                        e_reg <= '0;
                    end
                    else
                    begin
                        state_reg <= S_BPW;
                        phase_reg <= 1'b0;
                    end
                end
                S_BPW:
                begin
                    if (phase_reg)
                    begin
                        e_reg <= e_reg + 1'b1;
                        state_reg <= S_BP;
                    end
                    phase_reg <= !phase_reg;
                end
                S_DONE:
                    if (rsp_load)
                    begin
                        rsp_reg <= res_reg;
                        phase_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // a stalled response stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed");
    a_no_accept_clr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> !req_ready)
        else $error("request taken during clear sweep");
    a_read_zero_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.bad_request) |-> rsp.read_data == '0)
        else $error("bad request carries data");
endmodule
`default_nettype wire
